>>> design/latency_load_monitor_unit_defines.svh
// Assertion macros for the latency load monitor.
// Used by latency_load_monitor_unit; expects aclk and aresetn in scope.
`ifndef LATENCY_LOAD_MONITOR_UNIT_DEFINES_SVH
`define LATENCY_LOAD_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication under reset.
`define LLM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define LLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/llm_pkg.sv
// Shared types and constants of the latency load monitor.
// Used by llm_ctrl, llm_datapath and latency_load_monitor_unit.
package llm_pkg;

    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFGQ_DEPTH = 4;
    localparam int CFGQ_PTR_W = 2;

    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DECLINE_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_DISABLED = 1'b1;

    localparam logic [31:0] SAMPLE_LIMIT = 32'd65536;

    // Product sequence of the variance numerator and divisor.
    localparam logic [2:0] MUL_N_SQLO = 3'd0;
    localparam logic [2:0] MUL_N_SQHI = 3'd1;
    localparam logic [2:0] MUL_TL_TL  = 3'd2;
    localparam logic [2:0] MUL_TL_TH  = 3'd3;
    localparam logic [2:0] MUL_TH_TH  = 3'd4;
    localparam logic [2:0] MUL_N_N1   = 3'd5;
    localparam logic [2:0] MUL_FLUSH  = 3'd6;
    localparam logic [2:0] MUL_DONE   = 3'd7;

    typedef enum logic [1:0] {
        DIV_MEAN = 2'd0,
        DIV_VAR  = 2'd1,
        DIV_LOAD = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic       accept;
        logic       tick;
        logic       decay_load;
        logic       decay_step;
        logic       cfg_apply;
        logic       sample_update;
        logic       mean_zero;
        logic       div_load;
        div_sel_t   div_sel;
        logic       div_step;
        logic       acc_clear;
        logic       mul_step;
        logic [2:0] mul_idx;
        logic       load_check;
        logic       out_load;
    } llm_cmd_t;

    typedef struct packed {
        logic cfg_pending;
        logic decay_last;
        logic div_last;
        logic count_zero;
        logic count_le1;
        logic load_div_needed;
    } llm_status_t;

endpackage

>>> design/llm_ctrl.sv
// Controller of the latency load monitor: sequences decay, sample update,
// mean, variance and load divisions. Depends on llm_pkg.
module llm_ctrl import llm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [ACTION_W-1:0] s_action,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output llm_cmd_t            cmd,
    input  llm_status_t         status
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_DECAY   = 9'b000000010,
        ST_SAMPLE  = 9'b000000100,
        ST_MEAN    = 9'b000001000,
        ST_MUL     = 9'b000010000,
        ST_VAR     = 9'b000100000,
        ST_CHECK   = 9'b001000000,
        ST_LOADDIV = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        KIND_CFG    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic [2:0] mul_idx_reg, mul_idx_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE) && !status.cfg_pending;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.mul_idx  = mul_idx_reg;
        state_next   = state_reg;
        kind_next    = kind_reg;
        mul_idx_next = mul_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (status.cfg_pending) begin
                    cmd.decay_load = 1'b1;
                    kind_next      = KIND_CFG;
                    state_next     = ST_DECAY;
                end else if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (s_action)
                        ACT_TICK: cmd.tick = 1'b1;
                        ACT_SAMPLE: begin
                            cmd.decay_load = 1'b1;
                            kind_next      = KIND_SAMPLE;
                            state_next     = ST_DECAY;
                        end
                        ACT_QUERY: begin
                            cmd.decay_load = 1'b1;
                            kind_next      = KIND_QUERY;
                            state_next     = ST_DECAY;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DECAY: begin
                cmd.decay_step = 1'b1;
                if (status.decay_last) begin
                    unique case (kind_reg)
                        KIND_CFG: begin
                            cmd.cfg_apply = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        KIND_SAMPLE: state_next = ST_SAMPLE;
                        KIND_QUERY: begin
                            if (status.count_zero) begin
                                cmd.mean_zero = 1'b1;
                                state_next    = ST_OUT;
                            end else begin
                                cmd.div_load = 1'b1;
                                cmd.div_sel  = DIV_MEAN;
                                state_next   = ST_MEAN;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SAMPLE: begin
                cmd.sample_update = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_MEAN: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    if (status.count_le1) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.acc_clear = 1'b1;
                        mul_idx_next  = MUL_N_SQLO;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_idx_reg == MUL_DONE) begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DIV_VAR;
                    state_next   = ST_VAR;
                end else begin
                    cmd.mul_step = 1'b1;
                    mul_idx_next = mul_idx_reg + 3'd1;
                end
            end
            ST_VAR: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.load_check = 1'b1;
                if (status.load_div_needed) begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = DIV_LOAD;
                    state_next   = ST_LOADDIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_LOADDIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_ready)          m_valid_next = 1'b0;
        else                       m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_CFG;
            mul_idx_reg <= MUL_N_SQLO;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            mul_idx_reg <= mul_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> design/llm_datapath.sv
// Datapath of the latency load monitor: statistics registers, decay step,
// shared 32x32 multiplier, shared restoring divider. Depends on llm_pkg.
module llm_datapath import llm_pkg::*; #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_DECAY_STEPS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [31:0]            s_sample_value,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]            cfg_wdata,
    input  llm_cmd_t               cmd,
    output llm_status_t            status,
    output logic [FRAC_BITS+6:0]   m_load_score,
    output logic [FRAC_BITS+16:0]  m_mean_delay
);

    localparam int AVG_W    = 17 + FRAC_BITS;
    localparam int LOAD_W   = 7 + FRAC_BITS;
    localparam int VAR_W    = 32 + FRAC_BITS;
    localparam int VAR100_W = VAR_W + 7;
    localparam int Q_W      = 32 + FRAC_BITS;
    localparam int ACC_W    = 98;
    localparam int DCNT_W   = $clog2(MAX_DECAY_STEPS + 1);
    localparam int DIVC_W   = $clog2(Q_W + 1);
    localparam int QCNT_W   = CFGQ_PTR_W + 1;
    localparam logic [LOAD_W-1:0] LOAD_CAP  = LOAD_W'(100 << FRAC_BITS);
    localparam logic [VAR_W-1:0]  VAR_FLOOR = VAR_W'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic [DCNT_W-1:0] DCNT_MAX  = DCNT_W'(MAX_DECAY_STEPS);

    // architectural state
    logic [31:0]       elapsed_reg;
    logic [AVG_W-1:0]  avg_reg;
    logic [47:0]       total_reg;
    logic [63:0]       sq_reg;
    logic [31:0]       count_reg;
    logic [LOAD_W-1:0] load_reg;
    logic [31:0]       period_reg;
    logic              disabled_reg;

    // working registers
    logic [31:0]        sample_reg;
    logic [31:0]        rem_ticks_reg;
    logic [DCNT_W-1:0]  dec_cnt_reg;
    logic [AVG_W-1:0]   mean_reg;
    logic [VAR_W-1:0]   var_reg;
    logic [VAR100_W-1:0] var100_reg;
    logic [63:0]        prod_reg;
    logic [2:0]         prod_sel_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [63:0]        nn1_reg;
    logic [63:0]        rem_reg;
    logic [Q_W-1:0]     dvd_reg;
    logic [63:0]        dsr_reg;
    logic [DIVC_W-1:0]  div_cnt_reg;
    div_sel_t           div_sel_reg;
    logic [LOAD_W-1:0]  m_load_reg;
    logic [AVG_W-1:0]   m_mean_reg;

    // configuration write queue
    logic [CFG_IDX_W-1:0]  cfgq_idx_reg  [CFGQ_DEPTH];
    logic [31:0]           cfgq_data_reg [CFGQ_DEPTH];
    logic [CFGQ_PTR_W-1:0] cfgq_wr_reg, cfgq_rd_reg;
    logic [QCNT_W-1:0]     cfgq_cnt_reg;
    logic                  cfgq_push;

    assign cfgq_push = cfg_wr_en && (cfgq_cnt_reg != QCNT_W'(CFGQ_DEPTH));

    // decay step
    logic                dec_hold, dec_zero;
    logic [AVG_W+2:0]    avg_x7;
    logic [AVG_W-1:0]    avg_decayed;
    assign dec_hold    = disabled_reg || (rem_ticks_reg < period_reg);
    assign dec_zero    = !dec_hold && ((period_reg == 32'd0) || (dec_cnt_reg == DCNT_MAX));
    assign avg_x7      = {avg_reg, 3'b000} - {3'b000, avg_reg};
    assign avg_decayed = avg_x7[AVG_W+2:3];

    // sample update
    logic [16:0]      s17;
    logic [AVG_W+2:0] avg_upd;
    assign s17     = sample_reg[16:0];
    assign avg_upd = avg_x7 + (AVG_W+3)'({s17, {FRAC_BITS{1'b0}}});

    // multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [31:0] tl;
    logic [15:0] th;
    assign tl = total_reg[31:0];
    assign th = total_reg[47:32];

    always_comb begin
        unique case (cmd.mul_idx)
            MUL_N_SQLO: begin mul_a = count_reg; mul_b = sq_reg[31:0]; end
            MUL_N_SQHI: begin mul_a = count_reg; mul_b = sq_reg[63:32]; end
            MUL_TL_TL:  begin mul_a = tl;        mul_b = tl; end
            MUL_TL_TH:  begin mul_a = tl;        mul_b = {16'd0, th}; end
            MUL_TH_TH:  begin mul_a = {16'd0, th}; mul_b = {16'd0, th}; end
            MUL_N_N1:   begin mul_a = count_reg; mul_b = count_reg - 32'd1; end
            default:    begin mul_a = 32'd0;     mul_b = 32'd0; end
        endcase
    end

    logic [ACC_W-1:0] prod_ext;
    assign prod_ext = ACC_W'(prod_reg);

    // divider step
    logic [64:0]    div_sh;
    logic           div_ge;
    logic [63:0]    div_rem_next;
    logic [Q_W-1:0] div_q_next;
    logic [64:0]    div_diff;
    assign div_sh       = {rem_reg, dvd_reg[Q_W-1]};
    assign div_diff     = div_sh - {1'b0, dsr_reg};
    assign div_ge       = div_sh >= {1'b0, dsr_reg};
    assign div_rem_next = div_ge ? div_diff[63:0] : div_sh[63:0];
    assign div_q_next   = {dvd_reg[Q_W-2:0], div_ge};

    logic [VAR_W-1:0]    var_fixed;
    logic [VAR100_W-1:0] var100_next;
    assign var_fixed   = (div_q_next[VAR_W-1:0] == '0) ? VAR_FLOOR : div_q_next[VAR_W-1:0];
    assign var100_next = (VAR100_W'(var_fixed) << 6) + (VAR100_W'(var_fixed) << 5)
                       + (VAR100_W'(var_fixed) << 2);

    // load check
    logic             avg_below, cap_hit;
    logic [AVG_W-1:0] diff;
    assign avg_below = avg_reg < mean_reg;
    assign diff      = avg_reg - mean_reg;
    assign cap_hit   = VAR100_W'(diff) >= var100_reg;

    // divider operand load
    logic [95:0]       d_pos;
    logic [63:0]       ld_rem, ld_dsr;
    logic [Q_W-1:0]    ld_dvd;
    logic [DIVC_W-1:0] ld_cnt;
    assign d_pos = acc_reg[ACC_W-1] ? 96'd0 : acc_reg[95:0];

    always_comb begin
        unique case (cmd.div_sel)
            DIV_MEAN: begin
                ld_rem = 64'(total_reg[47:17]);
                ld_dvd = {total_reg[16:0], {(Q_W-17){1'b0}}};
                ld_dsr = 64'(count_reg);
                ld_cnt = DIVC_W'(AVG_W);
            end
            DIV_VAR: begin
                ld_rem = d_pos[95:32];
                ld_dvd = {d_pos[31:0], {FRAC_BITS{1'b0}}};
                ld_dsr = nn1_reg;
                ld_cnt = DIVC_W'(Q_W);
            end
            DIV_LOAD: begin
                ld_rem = 64'(diff[AVG_W-1:7]);
                ld_dvd = {diff[6:0], {(Q_W-7){1'b0}}};
                ld_dsr = 64'(var_reg);
                ld_cnt = DIVC_W'(LOAD_W);
            end
            default: begin
                ld_rem = 64'd0;
                ld_dvd = '0;
                ld_dsr = 64'd1;
                ld_cnt = DIVC_W'(1);
            end
        endcase
    end

    assign status.cfg_pending     = cfgq_cnt_reg != '0;
    assign status.decay_last      = dec_hold || dec_zero;
    assign status.div_last        = div_cnt_reg == DIVC_W'(1);
    assign status.count_zero      = count_reg == 32'd0;
    assign status.count_le1       = count_reg <= 32'd1;
    assign status.load_div_needed = !avg_below && !cap_hit;

    assign m_load_score = m_load_reg;
    assign m_mean_delay = m_mean_reg;

    // state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg  <= 32'd0;
            avg_reg      <= '0;
            total_reg    <= 48'd0;
            sq_reg       <= 64'd0;
            count_reg    <= 32'd0;
            load_reg     <= '0;
            period_reg   <= 32'd0;
            disabled_reg <= 1'b1;
            cfgq_wr_reg  <= '0;
            cfgq_rd_reg  <= '0;
            cfgq_cnt_reg <= '0;
        end else begin
            if (cfgq_push) cfgq_wr_reg <= cfgq_wr_reg + 1'b1;
            if (cmd.cfg_apply) begin
                cfgq_rd_reg <= cfgq_rd_reg + 1'b1;
                if (cfgq_idx_reg[cfgq_rd_reg] == CFG_DECLINE_PERIOD) begin
                    period_reg <= cfgq_data_reg[cfgq_rd_reg];
                end else begin
                    disabled_reg <= cfgq_data_reg[cfgq_rd_reg][0];
                end
            end
            cfgq_cnt_reg <= cfgq_cnt_reg + QCNT_W'(cfgq_push) - QCNT_W'(cmd.cfg_apply);

            if (cmd.tick && (elapsed_reg != 32'hFFFF_FFFF)) begin
                elapsed_reg <= elapsed_reg + 32'd1;
            end
            if (cmd.decay_step && !dec_hold) begin
                if (dec_zero) begin
                    avg_reg  <= '0;
                    load_reg <= '0;
                end else begin
                    avg_reg <= avg_decayed;
                end
            end
            if (cmd.sample_update) begin
                elapsed_reg <= 32'd0;
                if (sample_reg > SAMPLE_LIMIT) begin
                    load_reg <= LOAD_CAP;
                end else begin
                    // freeze the sums once the count saturates
                    if (count_reg != 32'hFFFF_FFFF) begin
                        total_reg <= total_reg + 48'(s17);
                        sq_reg    <= sq_reg + 64'(s17) * 64'(s17);
                        count_reg <= count_reg + 32'd1;
                    end
                    avg_reg <= avg_upd[AVG_W+2:3];
                end
            end
            if (cmd.load_check && !status.load_div_needed) begin
                load_reg <= avg_below ? '0 : LOAD_CAP;
            end
            if (cmd.div_step && status.div_last && (div_sel_reg == DIV_LOAD)) begin
                load_reg <= div_q_next[LOAD_W-1:0];
            end
        end
    end

    // working registers, no reset
    always_ff @(posedge aclk) begin
        if (cfgq_push) begin
            cfgq_idx_reg[cfgq_wr_reg]  <= cfg_index;
            cfgq_data_reg[cfgq_wr_reg] <= cfg_wdata;
        end
        if (cmd.accept) sample_reg <= s_sample_value;
        if (cmd.decay_load) begin
            rem_ticks_reg <= elapsed_reg;
            dec_cnt_reg   <= '0;
        end else if (cmd.decay_step && !dec_hold && !dec_zero) begin
            rem_ticks_reg <= rem_ticks_reg - period_reg;
            dec_cnt_reg   <= dec_cnt_reg + 1'b1;
        end
        if (cmd.mean_zero) mean_reg <= '0;
        if (cmd.acc_clear) acc_reg <= '0;
        if (cmd.mul_step) begin
            prod_reg     <= mul_a * mul_b;
            prod_sel_reg <= cmd.mul_idx;
            // accumulate the product issued in the previous cycle
            if (cmd.mul_idx != MUL_N_SQLO) begin
                unique case (prod_sel_reg)
                    MUL_N_SQLO: acc_reg <= acc_reg + prod_ext;
                    MUL_N_SQHI: acc_reg <= acc_reg + (prod_ext << 32);
                    MUL_TL_TL:  acc_reg <= acc_reg - prod_ext;
                    MUL_TL_TH:  acc_reg <= acc_reg - (prod_ext << 33);
                    MUL_TH_TH:  acc_reg <= acc_reg - (prod_ext << 64);
                    MUL_N_N1:   nn1_reg <= prod_reg;
                    default: ;
                endcase
            end
        end
        if (cmd.div_load) begin
            rem_reg     <= ld_rem;
            dvd_reg     <= ld_dvd;
            dsr_reg     <= ld_dsr;
            div_cnt_reg <= ld_cnt;
            div_sel_reg <= cmd.div_sel;
        end else if (cmd.div_step) begin
            rem_reg     <= div_rem_next;
            dvd_reg     <= div_q_next;
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (status.div_last) begin
                unique case (div_sel_reg)
                    DIV_MEAN: mean_reg <= div_q_next[AVG_W-1:0];
                    DIV_VAR: begin
                        var_reg    <= var_fixed;
                        var100_reg <= var100_next;
                    end
                    default: ;
                endcase
            end
        end
        if (cmd.out_load) begin
            m_load_reg <= load_reg;
            m_mean_reg <= mean_reg;
        end
    end

endmodule

>>> design/latency_load_monitor_unit.sv
// Top level of the latency load monitor: controller plus datapath.
// Depends on llm_pkg, llm_ctrl, llm_datapath, latency_load_monitor_unit_defines.svh.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------
//   input    | s_valid / s_ready  | s_action, s_sample_value
//   result   | m_valid / m_ready  | m_load_score, m_mean_delay
//   config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// A sample runs the one-step-per-cycle decay loop and then its update. A query
// adds the bit-serial divider for the mean (17+F quotient bits), the variance
// (32+F) and the load (7+F), and the multiplier pass between mean and variance,
// each only when needed; F is FRAC_BITS, Q.16 by default.
// A config write is queued and runs its decay pass before the next input
// transaction is taken.
// Reset is synchronous; the output register lets a query finish while the
// previous result stalls, and the block waits only when it must replace it.
`include "latency_load_monitor_unit_defines.svh"

module latency_load_monitor_unit import llm_pkg::*; #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_DECAY_STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ACTION_W-1:0]   s_action,
    input  logic [31:0]           s_sample_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FRAC_BITS+6:0]  m_load_score,
    output logic [FRAC_BITS+16:0] m_mean_delay,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_wdata
);

    localparam int LOAD_W = 7 + FRAC_BITS;
    localparam logic [LOAD_W-1:0] LOAD_CAP = LOAD_W'(100 << FRAC_BITS);

    llm_cmd_t    cmd;
    llm_status_t status;

    llm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    llm_datapath #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_DECAY_STEPS (MAX_DECAY_STEPS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_sample_value (s_sample_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .status         (status),
        .m_load_score   (m_load_score),
        .m_mean_delay   (m_mean_delay)
    );

    `LLM_ASSERT_NEXT(a_query_busy, s_valid && s_ready && s_action == ACT_QUERY, !s_ready, "input taken while a query runs")
    `LLM_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr_en, !s_ready, "input taken before config decay")
    `LLM_ASSERT_SAME(a_load_capped, m_valid, m_load_score <= LOAD_CAP, "load score above cap")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for latency_load_monitor_unit: random ticks, samples, queries and unused actions.
// Depends on llm_pkg and the RTL of the block; predicts each query result internally.
module tb;
    import llm_pkg::*;

    localparam int          FRAC       = 16;
    localparam logic [63:0] LOAD_CAP   = 64'd100 << FRAC;
    localparam logic [63:0] VAR_MIN    = 64'd655;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
    } latency_event_t;

    typedef struct packed {
        logic [22:0] load;
        logic [32:0] mean;
    } load_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_TICK;
    logic [31:0] s_sample_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [22:0] m_load_score;
    logic [32:0] m_mean_delay;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_DECLINE_PERIOD;
    logic [31:0] cfg_wdata = '0;

    latency_event_t event_q[$];
    load_report_t   report_q[$];
    int             err_count = 0;
    int             send_gap_pct = 16;
    int             recv_gap_pct = 78;
    int             hold_cycles = 0;
    bit             taken = 1'b0;

    // model state
    logic [31:0] period_r;
    logic        no_decay_r;
    logic [31:0] elapsed;
    logic [63:0] avg;
    logic [47:0] total;
    logic [63:0] sq_total;
    logic [31:0] count;
    logic [63:0] load_r;

    latency_load_monitor_unit dut (.*);

    always #6 aclk = ~aclk;

    function automatic void lazy_decay();
        logic [31:0] steps;
        if (no_decay_r || elapsed < period_r)
            return;
        if (period_r == 0) begin
            avg = 0;
            load_r = 0;
            return;
        end
        steps = elapsed / period_r;
        if (steps > 16) begin
            avg = 0;
            load_r = 0;
            return;
        end
        repeat (steps) avg = (avg * 7) >> 3;
    endfunction

    function automatic logic [63:0] mean_delay();
        logic [63:0] scaled;
        scaled = {16'b0, total} << FRAC;
        return (count == 0) ? 64'd0 : scaled / count;
    endfunction

    function automatic void update_load(logic [63:0] mean);
        logic [127:0] n, lhs, rhs, num, var_wide, q;
        logic [63:0]  var_q, diff;
        if (count <= 1)
            return;
        n = count;
        lhs = n * {64'b0, sq_total};
        rhs = {80'b0, total} * {80'b0, total};
        num = (lhs < rhs) ? 128'd0 : lhs - rhs;
        num = num << FRAC;
        var_wide = num / (n * (n - 1));
        var_q = var_wide[63:0];
        if (var_q == 0)
            var_q = VAR_MIN;
        if (avg < mean) begin
            load_r = 0;
            return;
        end
        diff = avg - mean;
        if (diff / 100 >= var_q) begin
            load_r = LOAD_CAP;
            return;
        end
        q = ({64'b0, diff} << FRAC) / var_q;
        load_r = (q > LOAD_CAP) ? LOAD_CAP : q[63:0];
    endfunction

    function automatic void predict_event(latency_event_t ev);
        logic [63:0]  mean;
        load_report_t rep;
        case (ev.action)
            ACT_TICK: begin
                if (elapsed != 32'hFFFF_FFFF)
                    elapsed++;
            end
            ACT_SAMPLE: begin
                lazy_decay();
                elapsed = 0;
                if (ev.value > SAMPLE_LIMIT) begin
                    load_r = LOAD_CAP;
                end else begin
                    if (count != 32'hFFFF_FFFF) begin
                        total += ev.value;
                        sq_total += {32'b0, ev.value} * {32'b0, ev.value};
                        count++;
                    end
                    avg = (avg * 7 + ({32'b0, ev.value} << FRAC)) >> 3;
                end
            end
            ACT_QUERY: begin
                lazy_decay();
                mean = mean_delay();
                update_load(mean);
                rep.load = load_r[22:0];
                rep.mean = mean[32:0];
                report_q.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // input driver
    always @(posedge aclk) begin
        taken = 1'b0;
        if (aresetn && s_valid && s_ready) begin
            predict_event('{s_action, s_sample_value});
            taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || taken) begin
            if (aresetn && event_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                s_valid <= 1'b1;
                s_action <= event_q[0].action;
                s_sample_value <= event_q[0].value;
                void'(event_q.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_load_score, 0);
            end else begin
                if (m_load_score !== report_q[0].load)
                    report_mismatch("load_score", m_load_score, report_q[0].load);
                if (m_mean_delay !== report_q[0].mean)
                    report_mismatch("mean_delay", m_mean_delay, report_q[0].mean);
                void'(report_q.pop_front());
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        lazy_decay();
        if (idx == CFG_DECLINE_PERIOD)
            period_r = data;
        else
            no_decay_r = data[0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push(logic [1:0] act, logic [31:0] val);
        event_q.push_back('{act, val});
    endtask

    task automatic push_random(int n);
        int r;
        logic [31:0] val;
        repeat (n) begin
            r = $urandom_range(99);
            case ($urandom_range(9))
                0:       val = $urandom();
                1:       val = $urandom_range(65536, 60000);
                default: val = $urandom_range(2000);
            endcase
            if (r < 50)
                push(ACT_TICK, $urandom());
            else if (r < 80)
                push(ACT_SAMPLE, val);
            else if (r < 95)
                push(ACT_QUERY, $urandom());
            else
                push(ACT_UNUSED, val);
        end
    endtask

    // drain everything, then let any trailing decay pass settle
    task automatic wait_idle();
        wait (event_q.size() == 0 && !s_valid && report_q.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        period_r = 0;
        no_decay_r = 1'b1;
        elapsed = 0;
        avg = 0;
        total = 0;
        sq_total = 0;
        count = 0;
        load_r = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty query, extreme samples, unused action
        push(ACT_QUERY, 0);
        push(ACT_SAMPLE, 0);
        push(ACT_QUERY, 0);
        push(ACT_SAMPLE, 65536);
        push(ACT_QUERY, 0);
        push(ACT_SAMPLE, 65537);
        push(ACT_QUERY, 0);
        push(ACT_SAMPLE, 32'hFFFF_FFFF);
        push(ACT_UNUSED, 32'hFFFF_FFFF);
        push(ACT_SAMPLE, 100);
        push(ACT_SAMPLE, 100);
        push(ACT_QUERY, 32'hFFFF_FFFF);
        push(ACT_TICK, 0);
        push(ACT_TICK, 32'hFFFF_FFFF);
        push(ACT_QUERY, 0);
        wait_idle();

        // zero period with decay on clears average and load
        write_reg(CFG_DECAY_DISABLED, 32'd0);
        push(ACT_SAMPLE, 5000);
        push(ACT_QUERY, 0);
        push_random(320);
        wait_idle();

        write_reg(CFG_DECLINE_PERIOD, 32'd4);
        repeat (12) push(ACT_TICK, 0);
        push(ACT_QUERY, 0);
        repeat (70) push(ACT_TICK, 0);
        push(ACT_SAMPLE, 300);
        push(ACT_QUERY, 0);
        push_random(320);
        wait_idle();

        send_gap_pct = 78;
        recv_gap_pct = 16;
        write_reg(CFG_DECLINE_PERIOD, 32'hFFFF_FFFF);
        push_random(320);
        wait_idle();

        write_reg(CFG_DECLINE_PERIOD, 32'd1);
        write_reg(CFG_DECAY_DISABLED, 32'd1);
        push_random(320);
        wait_idle();

        // no idling; long receiver stall backs up the block
        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_reg(CFG_DECAY_DISABLED, 32'd0);
        write_reg(CFG_DECLINE_PERIOD, 32'd2);
        hold_cycles = 2000;
        repeat (40) push(ACT_QUERY, 0);
        push_random(230);
        wait_idle();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
